### rtl/core/tile_segment_stream_decoder_defines.svh
// Assertion macros for the tile segment stream decoder.
`ifndef TILE_SEGMENT_STREAM_DECODER_DEFINES_SVH
`define TILE_SEGMENT_STREAM_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define TSD_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TSD_ASSERT(label, prop, msg) \
    `TSD_ASSERT_CLK(label, aclk, aresetn, prop, msg)
`else
`define TSD_ASSERT_CLK(label, clk, rstn, prop, msg)
`define TSD_ASSERT(label, prop, msg)
`endif

`endif

### rtl/core/tssd_pkg.sv
// Shared types and constants for the tile segment stream decoder.
`timescale 1ns / 1ps

package tssd_pkg;

    localparam int GRID_BITS  = 6;                 // 64 x 64 grid
    localparam int CELL_BITS  = 2 * GRID_BITS;     // 4096 cells
    localparam int POS_BITS   = 14;
    localparam int LEN_BITS   = 16;
    localparam int COUNT_BITS = 6;
    localparam int MAX_RUN    = 32;
    localparam int EPOCH_BITS = 8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ODD_JUMP  = 3'd1;
    localparam logic [2:0] ST_TRUNCATED = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_OVERLAP   = 3'd4;
    localparam logic [2:0] ST_NO_TERM   = 3'd5;
    localparam logic [2:0] ST_TRAILING  = 3'd6;

    typedef struct packed {
        logic [7:0]          data_byte;
        logic                first_byte;
        logic [LEN_BITS-1:0] total_length;
    } in_t;

    typedef struct packed {
        logic                 tile_valid;
        logic [GRID_BITS-1:0] tile_col;
        logic [GRID_BITS-1:0] tile_row;
        logic [15:0]          tile_data;
        logic                 finished;
        logic [2:0]           status_code;
    } out_t;

    typedef struct packed {
        logic [CELL_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [CELL_BITS-1:0] wr_addr;
        logic                 new_object;
        logic                 start_sweep;
    } occ_req_t;

    typedef struct packed {
        logic occupied;
        logic sweeping;
        logic epoch_full;
    } occ_stat_t;

endpackage

### rtl/core/tssd_occ.sv
// Occupancy map: epoch-tagged cell memory with a clearing sweep.
`timescale 1ns / 1ps

module tssd_occ
    import tssd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  occ_req_t  req,
    output occ_stat_t stat
);

    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;
    localparam logic [CELL_BITS-1:0]  ADDR_LAST = '1;

    logic [EPOCH_BITS-1:0] tag_mem [2**CELL_BITS];
    logic [EPOCH_BITS-1:0] rd_tag_reg;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic                  sweep_reg, sweep_next;
    logic [CELL_BITS-1:0]  sweep_addr_reg, sweep_addr_next;

    logic                  mem_we;
    logic [CELL_BITS-1:0]  mem_waddr;
    logic [EPOCH_BITS-1:0] mem_wdata;

    always_comb begin
        epoch_next      = epoch_reg;
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        mem_we          = req.wr_en;
        mem_waddr       = req.wr_addr;
        mem_wdata       = epoch_reg;
        if (sweep_reg) begin
            // clear one tag a cycle; restart epochs when the last goes
            mem_we          = 1'b1;
            mem_waddr       = sweep_addr_reg;
            mem_wdata       = '0;
            sweep_addr_next = sweep_addr_reg + 1'b1;
            if (sweep_addr_reg == ADDR_LAST) begin
                sweep_next = 1'b0;
                epoch_next = '0;
            end
        end else if (req.start_sweep) begin
            sweep_next      = 1'b1;
            sweep_addr_next = '0;
        end else if (req.new_object) begin
            epoch_next = epoch_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg      <= '0;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
        end else begin
            epoch_reg      <= epoch_next;
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tag_mem[mem_waddr] <= mem_wdata;
        end
        rd_tag_reg <= tag_mem[req.rd_addr];
    end

    assign stat.occupied   = (rd_tag_reg == epoch_reg);
    assign stat.sweeping   = sweep_reg;
    assign stat.epoch_full = (epoch_reg == EPOCH_MAX);

endmodule

### rtl/core/tile_segment_stream_decoder.sv
// Top level of the tile segment stream decoder.
//
//  channel | direction | payload | handshake
//  s_      | in        | in_t    | s_valid / s_ready
//  m_      | out       | out_t   | m_valid / m_ready
//
// One byte per cycle while s_ready is high; each result is registered in the output buffer before it shows on m_.
// The occupancy map is a 4096-entry tag memory whose registered read is addressed ahead of use.
// After reset, and before the first byte of an object that finds the 8-bit epoch full, a clearing pass
// over the whole tag memory runs with s_ready low.
// A two-beat output buffer takes results while m_ready is low; s_ready also drops
// when both beats are full.
`timescale 1ns / 1ps
`include "tile_segment_stream_decoder_defines.svh"

module tile_segment_stream_decoder
    import tssd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam logic [1:0] PH_HDR_LO  = 2'd0;
    localparam logic [1:0] PH_HDR_HI  = 2'd1;
    localparam logic [1:0] PH_TILE_LO = 2'd2;
    localparam logic [1:0] PH_TILE_HI = 2'd3;

    logic [1:0]            phase_reg, phase_next;
    logic [7:0]            hdr_lo_reg, hdr_lo_next;
    logic [COUNT_BITS-1:0] tiles_reg, tiles_next;
    logic [6:0]            jump_half_reg, jump_half_next;
    logic [POS_BITS-1:0]   base_reg, base_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [7:0]            tile_lo_reg, tile_lo_next;
    logic [LEN_BITS-1:0]   seen_reg, seen_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic                  done_reg, done_next;

    out_t head_reg, skid_reg;
    logic head_valid_reg, skid_valid_reg;

    occ_req_t  occ_req;
    occ_stat_t occ_stat;

    logic                  accept, proc, first, push, pop;
    logic [1:0]            cur_phase;
    logic [LEN_BITS-1:0]   cur_len;
    logic [POS_BITS-1:0]   cur_pos;
    logic [15:0]           hdr, hdr_diff;
    logic [COUNT_BITS-1:0] cnt;
    logic [7:0]            jump;
    logic [LEN_BITS:0]     need;
    logic                  in_grid;
    out_t                  res;

    tssd_occ u_occ (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (occ_req),
        .stat    (occ_stat)
    );

    assign first  = s_data.first_byte;
    assign s_ready = !skid_valid_reg && !occ_stat.sweeping
                     && !(first && occ_stat.epoch_full);
    assign accept = s_valid && s_ready;
    assign proc   = accept && (first || !done_reg);

    always_comb begin
        phase_next     = phase_reg;
        hdr_lo_next    = hdr_lo_reg;
        tiles_next     = tiles_reg;
        jump_half_next = jump_half_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        tile_lo_next   = tile_lo_reg;
        seen_next      = seen_reg;
        len_next       = len_reg;
        done_next      = done_reg;
        res            = '0;

        cur_phase = first ? PH_HDR_LO : phase_reg;
        cur_pos   = first ? '0 : pos_reg;
        if (first) begin
            cur_len = (s_data.total_length == '0) ? LEN_BITS'(1) : s_data.total_length;
        end else begin
            cur_len = len_reg;
        end

        hdr      = {s_data.data_byte, hdr_lo_reg};
        cnt      = (hdr[4:0] == 5'd0) ? COUNT_BITS'(MAX_RUN) : {1'b0, hdr[4:0]};
        hdr_diff = hdr - {10'd0, cnt};
        jump     = hdr_diff[15:8];
        in_grid  = (cur_pos[POS_BITS-1:CELL_BITS] == '0);
        need     = '0;

        if (proc) begin
            seen_next = (first ? LEN_BITS'(0) : seen_reg) + LEN_BITS'(1);
            len_next  = cur_len;
            pos_next  = cur_pos;
            need      = {1'b0, seen_next} + {{(LEN_BITS-COUNT_BITS){1'b0}}, cnt, 1'b0};
            case (cur_phase)
                PH_HDR_LO: begin
                    hdr_lo_next = s_data.data_byte;
                    phase_next  = PH_HDR_HI;
                end
                PH_HDR_HI: begin
                    if (hdr == 16'd0) begin
                        res.finished    = 1'b1;
                        res.status_code = (seen_next == cur_len) ? ST_OK : ST_TRAILING;
                    end else if (jump[0]) begin
                        res.finished    = 1'b1;
                        res.status_code = ST_ODD_JUMP;
                    end else if (need > {1'b0, cur_len}) begin
                        res.finished    = 1'b1;
                        res.status_code = ST_TRUNCATED;
                    end else begin
                        tiles_next     = cnt;
                        jump_half_next = jump[7:1];
                        base_next      = cur_pos;
                        phase_next     = PH_TILE_LO;
                    end
                end
                PH_TILE_LO: begin
                    if (!in_grid) begin
                        res.finished    = 1'b1;
                        res.status_code = ST_OUTSIDE;
                    end else if (occ_stat.occupied) begin
                        res.finished    = 1'b1;
                        res.status_code = ST_OVERLAP;
                    end else begin
                        tile_lo_next = s_data.data_byte;
                        phase_next   = PH_TILE_HI;
                    end
                end
                PH_TILE_HI: begin
                    if (in_grid) begin
                        res.tile_valid = 1'b1;
                        res.tile_col   = cur_pos[GRID_BITS-1:0];
                        res.tile_row   = cur_pos[CELL_BITS-1:GRID_BITS];
                        res.tile_data  = {s_data.data_byte, tile_lo_reg};
                    end
                    tiles_next = (tiles_reg != '0) ? tiles_reg - 1'b1 : '0;
                    if (tiles_next == '0) begin
                        // segment done: jump from its start
                        pos_next   = base_reg + {{(POS_BITS-7){1'b0}}, jump_half_reg};
                        phase_next = PH_HDR_LO;
                    end else begin
                        pos_next   = cur_pos + 1'b1;
                        phase_next = PH_TILE_LO;
                    end
                end
                default: begin
                    phase_next = PH_HDR_LO;
                end
            endcase
            if (!res.finished && seen_next >= cur_len) begin
                res.finished    = 1'b1;
                res.status_code = ST_NO_TERM;
            end
            done_next = res.finished;
        end
    end

    // prefetch the tag of the cell the next tile low byte will test
    always_comb begin
        occ_req.rd_addr     = pos_next[CELL_BITS-1:0];
        occ_req.wr_en       = proc && (cur_phase == PH_TILE_LO) && in_grid
                              && !occ_stat.occupied;
        occ_req.wr_addr     = cur_pos[CELL_BITS-1:0];
        occ_req.new_object  = accept && first;
        occ_req.start_sweep = s_valid && first && occ_stat.epoch_full
                              && !occ_stat.sweeping;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR_LO;
            hdr_lo_reg    <= '0;
            tiles_reg     <= '0;
            jump_half_reg <= '0;
            base_reg      <= '0;
            pos_reg       <= '0;
            tile_lo_reg   <= '0;
            seen_reg      <= '0;
            len_reg       <= '0;
            done_reg      <= 1'b1;
        end else begin
            phase_reg     <= phase_next;
            hdr_lo_reg    <= hdr_lo_next;
            tiles_reg     <= tiles_next;
            jump_half_reg <= jump_half_next;
            base_reg      <= base_next;
            pos_reg       <= pos_next;
            tile_lo_reg   <= tile_lo_next;
            seen_reg      <= seen_next;
            len_reg       <= len_next;
            done_reg      <= done_next;
        end
    end

    // two-beat output buffer
    assign push = proc && (res.tile_valid || res.finished);
    assign pop  = head_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                head_valid_reg <= skid_valid_reg || push;
                skid_valid_reg <= skid_valid_reg && push;
            end else if (push) begin
                head_valid_reg <= 1'b1;
                skid_valid_reg <= head_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            head_reg <= skid_valid_reg ? skid_reg : res;
            if (skid_valid_reg) begin
                skid_reg <= res;
            end
        end else if (push) begin
            if (head_valid_reg) begin
                skid_reg <= res;
            end else begin
                head_reg <= res;
            end
        end
    end

    assign m_valid = head_valid_reg;
    assign m_data  = head_reg;

    `TSD_ASSERT(a_skid_behind_head, skid_valid_reg |-> head_valid_reg, "skid without head")
    `TSD_ASSERT(a_no_write_in_sweep, occ_req.wr_en |-> !occ_stat.sweeping, "tile write in sweep")
    `TSD_ASSERT(a_done_after_status, (push && res.finished) |=> done_reg, "object left open")
    `TSD_ASSERT(a_tile_beat, (proc && !first && phase_reg == PH_TILE_HI) |-> push, "no tile beat")

endmodule

### sim/tb_tile_segment_stream_decoder.sv
// Self-checking testbench for the tile segment stream decoder: byte stimulus and result checking.
`timescale 1ns / 1ps

import tssd_pkg::*;

class tile_decode_scoreboard;
    typedef enum logic [1:0] {HEADER_LO, HEADER_HI, TILE_LO, TILE_HI} parse_phase_t;

    out_t                     expected_q[$];
    bit [(1<<CELL_BITS)-1:0]  occupied;
    parse_phase_t             phase;
    logic [7:0]               header_low;
    logic [7:0]               tile_low;
    int                       tiles_left;
    int                       jump_tiles;
    int                       segment_base;
    int                       tile_pos;
    int                       bytes_seen;
    int                       object_len;
    bit                       object_done;
    int                       mismatches;
    int                       consumed;

    function new();
        clear_object();
        object_done = 1'b1;
        mismatches  = 0;
        consumed    = 0;
    endfunction

    function void clear_object();
        occupied     = '0;
        phase        = HEADER_LO;
        header_low   = '0;
        tile_low     = '0;
        tiles_left   = 0;
        jump_tiles   = 0;
        segment_base = 0;
        tile_pos     = 0;
        bytes_seen   = 0;
        object_len   = 0;
    endfunction

    // Advance the decoder by one byte; return 1 when the byte yields a result.
    function bit decode_byte(in_t beat, output out_t res);
        logic [15:0] header;
        logic [15:0] less_count;
        int          count;
        bit          fin;
        logic [2:0]  status;
        consumed++;
        res    = '0;
        fin    = 1'b0;
        status = ST_OK;
        if (beat.first_byte) begin
            clear_object();
            object_len  = (beat.total_length == '0) ? 1 : int'(beat.total_length);
            object_done = 1'b0;
        end else if (object_done) begin
            return 1'b0;
        end
        bytes_seen++;
        case (phase)
            HEADER_LO: begin
                header_low = beat.data_byte;
                phase      = HEADER_HI;
            end
            HEADER_HI: begin
                header = {beat.data_byte, header_low};
                if (header == '0) begin
                    fin    = 1'b1;
                    status = (bytes_seen == object_len) ? ST_OK : ST_TRAILING;
                end else begin
                    count      = (header[4:0] == '0) ? MAX_RUN : int'(header[4:0]);
                    // jump in bytes is bits 15:8 of the difference, borrow kept
                    less_count = header - 16'(count);
                    if (less_count[8]) begin
                        fin    = 1'b1;
                        status = ST_ODD_JUMP;
                    end else if (bytes_seen + 2 * count > object_len) begin
                        fin    = 1'b1;
                        status = ST_TRUNCATED;
                    end else begin
                        tiles_left   = count;
                        jump_tiles   = int'(less_count[15:9]);
                        segment_base = tile_pos;
                        phase        = TILE_LO;
                    end
                end
            end
            TILE_LO: begin
                if (tile_pos >= (1 << CELL_BITS)) begin
                    fin    = 1'b1;
                    status = ST_OUTSIDE;
                end else if (occupied[tile_pos]) begin
                    fin    = 1'b1;
                    status = ST_OVERLAP;
                end else begin
                    occupied[tile_pos] = 1'b1;
                    tile_low           = beat.data_byte;
                    phase              = TILE_HI;
                end
            end
            TILE_HI: begin
                res.tile_valid = 1'b1;
                res.tile_col   = tile_pos[GRID_BITS-1:0];
                res.tile_row   = tile_pos[CELL_BITS-1:GRID_BITS];
                res.tile_data  = {beat.data_byte, tile_low};
                tile_pos++;
                tiles_left--;
                if (tiles_left == 0) begin
                    tile_pos = segment_base + jump_tiles;
                    phase    = HEADER_LO;
                end else begin
                    phase = TILE_LO;
                end
            end
            default: ;
        endcase
        if (!fin && bytes_seen >= object_len) begin
            fin    = 1'b1;
            status = ST_NO_TERM;
        end
        if (fin)
            object_done = 1'b1;
        res.finished    = fin;
        res.status_code = status;
        return res.tile_valid || fin;
    endfunction

    function void take_byte(in_t beat);
        out_t res;
        if (decode_byte(beat, res))
            expected_q = {expected_q, res};
    endfunction

    function string show(out_t r);
        return $sformatf("tile=%0d col=%0d row=%0d word=%h fin=%0d status=%0d",
                         r.tile_valid, r.tile_col, r.tile_row, r.tile_data,
                         r.finished, r.status_code);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_result(out_t got);
        out_t want;
        if (expected_q.size() == 0) begin
            report_mismatch({"result with none pending: ", show(got)});
            return;
        end
        want = expected_q.pop_front();
        if (got.tile_valid !== want.tile_valid || got.tile_col !== want.tile_col ||
            got.tile_row !== want.tile_row || got.tile_data !== want.tile_data ||
            got.finished !== want.finished || got.status_code !== want.status_code)
            report_mismatch({"got ", show(got), " expected ", show(want)});
    endtask
endclass

module tb_tile_segment_stream_decoder;
    typedef enum {CLEAN, FAR, SHORT, LONG, ODD_JUMP, OVERLAP, NOISE, ABANDON} flavour_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    tile_decode_scoreboard sb;
    logic [7:0]  object_bytes[$];
    logic [15:0] object_len;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    tile_segment_stream_decoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.take_byte(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(in_t beat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = beat;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_object();
        in_t beat;
        foreach (object_bytes[i]) begin
            beat.data_byte    = object_bytes[i];
            beat.first_byte   = (i == 0);
            beat.total_length = (i == 0) ? object_len : 16'($urandom);
            send_byte(beat);
        end
    endtask

    // Bytes without an object start: dropped when idle, else they continue the object.
    task automatic send_loose_bytes(int count);
        in_t beat;
        repeat (count) begin
            beat.data_byte    = 8'($urandom);
            beat.first_byte   = 1'b0;
            beat.total_length = 16'($urandom);
            send_byte(beat);
        end
    endtask

    task automatic add_segment(int n, int j);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [15:0] w;
        if (n < MAX_RUN) begin
            lo = {3'($urandom_range(7)), 5'(n)};
            hi = 8'(j);
        end else if (j < 255 && $urandom_range(1) == 1) begin
            // zero count field with clear bits 7:5 borrows from the high byte
            lo = 8'h00;
            hi = 8'(j + 1);
        end else begin
            lo = {3'($urandom_range(1, 7)), 5'd0};
            hi = 8'(j);
        end
        object_bytes = {object_bytes, lo};
        object_bytes = {object_bytes, hi};
        repeat (n) begin
            case ($urandom_range(7))
                0:       w = 16'h0000;
                1:       w = 16'hFFFF;
                default: w = 16'($urandom);
            endcase
            object_bytes = {object_bytes, w[7:0]};
            object_bytes = {object_bytes, w[15:8]};
        end
    endtask

    task automatic build_object();
        flavour_t kind;
        int       r;
        int       nseg;
        int       n;
        int       j;
        int       cut;
        r    = $urandom_range(99);
        kind = r < 55 ? CLEAN : r < 60 ? FAR : r < 67 ? SHORT : r < 73 ? LONG :
               r < 79 ? ODD_JUMP : r < 85 ? OVERLAP : r < 92 ? NOISE : ABANDON;
        object_bytes.delete();
        if (kind == NOISE) begin
            repeat ($urandom_range(1, 24))
                object_bytes = {object_bytes, 8'($urandom)};
            object_len = $urandom_range(1) ? 16'($urandom_range(1, 30)) : 16'($urandom);
            return;
        end
        // far objects step through the grid in long jumps, often past its end
        nseg = (kind == FAR) ? $urandom_range(24, 40) : $urandom_range(2, 4);
        for (int s = 0; s < nseg; s++) begin
            if (kind == FAR) begin
                n = $urandom_range(1, 2);
                j = 2 * $urandom_range(100, 127);
            end else begin
                n = ($urandom_range(9) == 0) ? MAX_RUN :
                    ($urandom_range(3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 4);
                j = 2 * $urandom_range(n, 127);
                if (s == 0 && kind == ODD_JUMP)
                    j = 2 * $urandom_range(0, 126) + 1;
                // jump short of the run lands the next segment on its own tiles
                if (s == 0 && kind == OVERLAP)
                    j = 2 * $urandom_range(0, n - 1);
            end
            add_segment(n, j);
        end
        object_bytes = {object_bytes, 8'h00};
        object_bytes = {object_bytes, 8'h00};
        object_len = 16'(object_bytes.size());
        case (kind)
            SHORT:   object_len = 16'($urandom_range(1, object_bytes.size() - 1));
            LONG:    object_len = 16'($urandom_range(object_bytes.size() + 1, 65535));
            ABANDON: begin
                cut = $urandom_range(1, object_bytes.size() - 1);
                while (object_bytes.size() > cut)
                    void'(object_bytes.pop_back());
            end
            default: ;
        endcase
    endtask

    initial begin
        int goal;
        int guard;
        sb      = new();
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // bytes before any object start
        send_loose_bytes(2);
        // zero length taken as one byte
        object_bytes = {8'hFF};
        object_len   = 16'd0;
        send_object();
        // terminator at the exact end, then with bytes left over
        object_bytes = {8'h00, 8'h00};
        object_len   = 16'd2;
        send_object();
        object_len   = 16'hFFFF;
        send_object();
        // count 32 whose borrow makes the jump odd
        object_bytes = {8'h00, 8'h02};
        object_len   = 16'd100;
        send_object();
        // count 32 that runs past the object length
        object_bytes = {8'h20, 8'h00};
        object_len   = 16'd10;
        send_object();
        // one tile, zero jump, then a second segment over the same cell
        object_bytes = {8'h01, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'hAA};
        object_len   = 16'd255;
        send_object();
        // tile completed by the last byte, with no terminator
        object_bytes = {8'h01, 8'h00, 8'h00, 8'h00};
        object_len   = 16'd4;
        send_object();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            goal = sb.consumed + 135;
            while (sb.consumed < goal) begin
                build_object();
                send_object();
                if ($urandom_range(9) == 0)
                    send_loose_bytes($urandom_range(1, 3));
            end
        end
        s_valid        = 1'b0;
        recv_stall_pct = 0;

        guard = 0;
        while (sb.expected_q.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.mismatches == 0)
            $display("tile_segment_stream_decoder test passed");
        else
            $display("tile_segment_stream_decoder test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tile_segment_stream_decoder test failed");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/tssd_pkg.sv
rtl/core/tssd_occ.sv
rtl/core/tile_segment_stream_decoder.sv
sim/tb_tile_segment_stream_decoder.sv
